// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the LED matrix scan controller RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/lmsc_pkg.sv
// Types and constants for the LED matrix scan controller.
// No dependencies.
package lmsc_pkg;

	localparam int ROWS          = 16;
	localparam int BYTES_PER_ROW = 4;
	localparam int COLS          = (8 * BYTES_PER_ROW < 32) ? 8 * BYTES_PER_ROW : 32;
	localparam int TICKS_PER_ROW = 10;
	localparam logic [3:0] BRIGHTNESS_RESET = 4'd5;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SET    = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_TOGGLE = 2'd3
	} op_t;

	typedef struct packed {
		op_t        operation;
		logic [4:0] pixel_x;
		logic [3:0] pixel_y;
	} item_t;

	typedef struct packed {
		logic        display_on;
		logic [3:0]  row_index;
		logic [31:0] row_pixels;
		logic        row_loaded;
	} result_t;

endpackage

// File: hw/rtl/lmsc_skid.sv
// Two-entry result buffer: output register plus skid stage.
// Depends on lmsc_pkg for result_t.
`include "assert_macros.svh"

module lmsc_skid import lmsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    out_valid_q;
	result_t out_data_q;
	logic    skid_valid_q;
	result_t skid_data_q;
	logic    load;

	assign in_stall  = skid_valid_q;
	assign load      = in_valid && !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && out_stall) begin
			if (load) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_stall) begin
			if (load) begin
				skid_data_q <= in_data;
			end
		end else if (skid_valid_q) begin
			out_data_q <= skid_data_q;
		end else if (load) begin
			out_data_q <= in_data;
		end
	end

	`ASSERT_IMPLY(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_valid_q && !out_stall, !skid_valid_q)
	`ASSERT_NEXT(a_out_held, clk, arst_n, out_valid_q && out_stall, out_valid_q && $stable(out_data_q))

endmodule

// File: hw/rtl/led_matrix_scan_controller.sv
// LED matrix scan controller top level: frame buffer, scan counter, PWM gate.
// Depends on lmsc_pkg and lmsc_skid; assertions from assert_macros.svh.
//
// Usage:
//   item channel (item_valid, item_stall, item): one request per accepted
//     item, either a scan tick or a set/clear/toggle of pixel (x, y).
//   result channel (result_valid, result_stall, result): one result per
//     request with display_on, row_index, row_pixels and row_loaded.
//   cfg channel (cfg_valid, cfg_ready, cfg_data): writes brightness; always
//     ready, write only while no request is in flight.
// Results are registered in lmsc_skid (output register or skid stage). One
//   request is taken every cycle while item_stall is low: the state update
//   is a single pass between the item handshake and the result register.
// Reset clears the 16 x 32 frame buffer, scan counter, row and outputs,
//   and sets brightness to 5. No clearing pass: it is ready at once.
// When the receiver stalls, results park in a two-entry buffer; item_stall
//   rises once both entries are full and falls as soon as one drains.
`include "assert_macros.svh"

module led_matrix_scan_controller import lmsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data
);

	logic [31:0] frame_q [ROWS];
	logic [3:0]  tick_q;
	logic [3:0]  row_q;
	logic        enabled_q;
	logic [31:0] latched_q;
	logic [3:0]  brightness_q;

	logic        accept;
	logic [3:0]  tick_inc;
	logic [3:0]  tick_nx;
	logic [3:0]  row_nx;
	logic        enabled_nx;
	logic [31:0] latched_nx;
	logic        loaded;
	logic        wrap;
	logic        pix_ok;
	logic [31:0] mask;
	logic [31:0] word_cur;
	logic [31:0] word_nx;
	logic [3:0]  row_inc;
	result_t     res;

	assign cfg_ready = 1'b1;
	assign accept    = item_valid && !item_stall;

	always_comb begin
		tick_inc   = tick_q + 4'd1;
		row_inc    = (row_q == 4'(ROWS - 1)) ? 4'd0 : row_q + 4'd1;
		tick_nx    = tick_q;
		row_nx     = row_q;
		enabled_nx = enabled_q;
		latched_nx = latched_q;
		loaded     = 1'b0;
		wrap       = 1'b0;
		pix_ok     = (5'(item.pixel_y) < 5'(ROWS)) && (6'(item.pixel_x) < 6'(COLS));
		mask       = 32'h8000_0000 >> item.pixel_x;
		word_cur   = frame_q[item.pixel_y];
		word_nx    = word_cur;
		if (item.operation == OP_TICK) begin
			tick_nx = tick_inc;
			if (tick_inc == brightness_q) begin
				enabled_nx = 1'b0;
			end
			if (tick_inc >= 4'(TICKS_PER_ROW)) begin
				wrap       = 1'b1;
				tick_nx    = 4'd0;
				row_nx     = row_inc;
				latched_nx = frame_q[row_inc];
				enabled_nx = 1'b1;
				loaded     = 1'b1;
			end
		end else begin
			case (item.operation)
				OP_SET:    word_nx = word_cur | mask;
				OP_CLEAR:  word_nx = word_cur & ~mask;
				default:   word_nx = word_cur ^ mask;
			endcase
		end
		res.display_on = enabled_nx;
		res.row_index  = row_nx;
		res.row_pixels = latched_nx;
		res.row_loaded = loaded;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= 4'd0;
			row_q        <= 4'd0;
			enabled_q    <= 1'b0;
			latched_q    <= 32'd0;
			brightness_q <= BRIGHTNESS_RESET;
			for (int r = 0; r < ROWS; r++) begin
				frame_q[r] <= 32'd0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				brightness_q <= cfg_data;
			end
			if (accept) begin
				tick_q    <= tick_nx;
				row_q     <= row_nx;
				enabled_q <= enabled_nx;
				latched_q <= latched_nx;
				if (item.operation != OP_TICK && pix_ok) begin
					frame_q[item.pixel_y] <= word_nx;
				end
			end
		end
	end

	lmsc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_stall  (item_stall),
		.in_data   (res),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_data  (result)
	);

	`ASSERT_ALWAYS(a_tick_range, clk, arst_n, tick_q < 4'(TICKS_PER_ROW))
	`ASSERT_ALWAYS(a_row_range, clk, arst_n, 5'(row_q) < 5'(ROWS))
	`ASSERT_NEXT(a_wrap_shows_row, clk, arst_n, accept && wrap,
		enabled_q && tick_q == 4'd0 && latched_q == frame_q[row_q])

endmodule

// File: sim/lmsc_scan_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the LED matrix scan controller: watches the request, result
// and brightness channels, predicts the drive state after each request and
// compares it field by field. Depends on lmsc_pkg.
module lmsc_scan_checker import lmsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_stall,
	input  item_t      item,
	input  logic       result_valid,
	input  logic       result_stall,
	input  result_t    result,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [3:0] cfg_data,
	output int         fails,
	output int         pending
);

	logic [31:0] frame_rows [ROWS];
	logic [3:0]  tick_count;
	logic [3:0]  scan_row;
	logic [3:0]  brightness;
	logic        lit;
	logic [31:0] shown_columns;
	result_t     expected_drive [$];

	function automatic result_t next_drive_state(input item_t req);
		result_t     drive;
		logic [31:0] mask;
		drive.row_loaded = 1'b0;
		if (req.operation == OP_TICK) begin
			tick_count = tick_count + 4'd1;
			if (tick_count == brightness)
				lit = 1'b0;
			if (tick_count >= TICKS_PER_ROW) begin
				tick_count = 4'd0;
				scan_row = (scan_row == 4'(ROWS - 1)) ? 4'd0 : scan_row + 4'd1;
				shown_columns = frame_rows[scan_row];
				lit = 1'b1;
				drive.row_loaded = 1'b1;
			end
		end else if (req.pixel_y < ROWS && req.pixel_x < COLS) begin
			mask = 32'h8000_0000 >> req.pixel_x;
			case (req.operation)
				OP_SET:   frame_rows[req.pixel_y] = frame_rows[req.pixel_y] | mask;
				OP_CLEAR: frame_rows[req.pixel_y] = frame_rows[req.pixel_y] & ~mask;
				default:  frame_rows[req.pixel_y] = frame_rows[req.pixel_y] ^ mask;
			endcase
		end
		drive.display_on = lit;
		drive.row_index  = scan_row;
		drive.row_pixels = shown_columns;
		return drive;
	endfunction

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++)
				frame_rows[r] = '0;
			tick_count = '0;
			scan_row = '0;
			brightness = BRIGHTNESS_RESET;
			lit = 1'b0;
			shown_columns = '0;
			expected_drive.delete();
			fails = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_drive.size() == 0) begin
					report($sformatf("result %h with no request outstanding", result));
				end else begin
					want = expected_drive.pop_front();
					if (result.display_on !== want.display_on)
						report($sformatf("display_on %b, expected %b",
							result.display_on, want.display_on));
					if (result.row_index !== want.row_index)
						report($sformatf("row_index %0d, expected %0d",
							result.row_index, want.row_index));
					if (result.row_pixels !== want.row_pixels)
						report($sformatf("row_pixels %h, expected %h",
							result.row_pixels, want.row_pixels));
					if (result.row_loaded !== want.row_loaded)
						report($sformatf("row_loaded %b, expected %b",
							result.row_loaded, want.row_loaded));
				end
			end
			if (cfg_valid && cfg_ready)
				brightness = cfg_data;
			if (item_valid && !item_stall)
				expected_drive.push_back(next_drive_state(item));
		end
		pending = expected_drive.size();
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Regression top for the LED matrix scan controller: drives pixel and tick
// requests, brightness writes and result back-pressure, and gives the verdict.
// Depends on lmsc_pkg, the controller RTL and lmsc_scan_checker.
module tb;
	import lmsc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 90;
	localparam int LONG_HOLD   = 80;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	item_t      item;
	logic       result_valid;
	logic       result_stall;
	result_t    result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [3:0] cfg_data;
	int         fails;
	int         pending;
	int         cycles;
	bit         quiet;
	bit         hold_req;
	logic [3:0] levels [8] = '{4'd0, 4'd10, 4'd15, 4'd1, 4'd9, 4'd3, 4'd11, 4'd7};

	led_matrix_scan_controller dut (.*);
	lmsc_scan_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("led_matrix_scan_controller regression: fail");
		$finish;
	end

	function automatic item_t pixel_req(input op_t op, input int x, input int y);
		item_t req;
		req.operation = op;
		req.pixel_x = 5'(x);
		req.pixel_y = 4'(y);
		return req;
	endfunction

	function automatic item_t random_req();
		item_t req;
		req.operation = ($urandom_range(0, 9) < 6) ? OP_TICK : op_t'($urandom_range(1, 3));
		req.pixel_x = 5'($urandom_range(0, 31));
		req.pixel_y = 4'($urandom_range(0, 15));
		return req;
	endfunction

	task automatic offer(input item_t req);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	task automatic write_brightness(input logic [3:0] level);
		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= level;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : receiver
		int stall_left;
		bit take_hold;
		bit stall_ok;
		bit held;
		result_stall = 1'b0;
		stall_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			take_hold = hold_req && !held;
			stall_ok = !quiet;
			@(negedge clk);
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else if (take_hold) begin
				held = 1'b1;
				stall_left = LONG_HOLD - 1;
				result_stall <= 1'b1;
			end else if (stall_ok && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 16);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		offer(pixel_req(OP_SET, 0, 0));
		offer(pixel_req(OP_SET, 31, 15));
		offer(pixel_req(OP_TOGGLE, 31, 0));
		offer(pixel_req(OP_CLEAR, 0, 0));
		offer(pixel_req(OP_TOGGLE, 0, 15));
		offer(pixel_req(OP_TOGGLE, 0, 1));
		offer(pixel_req(OP_SET, 31, 1));
		offer(pixel_req(OP_SET, 16, 1));
		offer(pixel_req(OP_SET, 15, 1));
		offer(pixel_req(OP_CLEAR, 16, 1));
		repeat (12) offer(pixel_req(OP_TICK, $urandom_range(0, 31), $urandom_range(0, 15)));

		for (int p = 0; p < 8; p++) begin
			write_brightness(levels[p]);
			quiet = (p == 7);
			hold_req = (p == 1);
			repeat (PHASE_ITEMS) offer(random_req());
		end

		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		if (fails == 0)
			$display("led_matrix_scan_controller regression: pass");
		else
			$display("led_matrix_scan_controller regression: fail");
		$finish;
	end

endmodule
